FILE: hw/rtl/b64u_pkg.sv
`default_nettype none

package b64u_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  localparam logic RES_DATA   = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int LVL_W      = 3;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  byte_value;
    status_t     status;
    logic [15:0] byte_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic             room;
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t    s;
    logic [7:0] t;
    s.ok = 1'b1;
    t    = 8'd0;
    if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
      t = ch - CHAR_UC_A;
    end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
      t = ch - 8'd71;
    end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
      t = ch + 8'd4;
    end else if (ch == CHAR_DASH) begin
      t = 8'd62;
    end else if (ch == CHAR_UNDER) begin
      t = 8'd63;
    end else begin
      s.ok = 1'b0;
    end
    s.val = t[5:0];
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64u_ifs.sv
`default_nettype none

interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       char_present;
  logic       end_of_message;

  modport source (output valid, character, char_present, end_of_message, input ready);
  modport sink   (input valid, character, char_present, end_of_message, output ready);
endinterface

interface b64u_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  byte_value;
  logic [1:0]  status;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, result_kind, byte_value, status, byte_count, last,
                  input ready);
  modport sink   (input valid, result_kind, byte_value, status, byte_count, last,
                  output ready);
endinterface

interface b64u_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/b64u_step.sv
`default_nettype none

module b64u_step #(
  parameter int COUNT_BITS = 16
) (
  input  logic [7:0]            character,
  input  logic                  char_present,
  input  logic                  end_of_message,
  input  logic [15:0]           capacity,
  input  logic [5:0]            lo_bits,
  input  logic [2:0]            lo_cnt,
  input  logic [COUNT_BITS-1:0] bytes_wr,
  input  b64u_pkg::status_t     err,
  output logic [5:0]            lo_bits_nxt,
  output logic [2:0]            lo_cnt_nxt,
  output logic [COUNT_BITS-1:0] bytes_wr_nxt,
  output b64u_pkg::status_t     err_nxt,
  output logic [1:0]            n_res,
  output b64u_pkg::res_t        res_a,
  output b64u_pkg::res_t        res_b
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  b64u_pkg::sextet_t      sx;
  b64u_pkg::status_t      err_mid;
  b64u_pkg::status_t      st_end;
  b64u_pkg::res_t         data_res;
  b64u_pkg::res_t         stat_res;
  logic                   use_char;
  logic [2:0]             cnt_c;
  logic [5:0]             mask_in;
  logic [5:0]             mask_out;
  logic [11:0]            acc;
  logic [3:0]             sum_cnt;
  logic                   full;
  logic [2:0]             rem;
  logic [7:0]             dbyte;
  logic                   no_space;
  logic                   emit;
  logic [5:0]             bits_mid;
  logic [2:0]             cnt_mid;
  logic [COUNT_BITS-1:0]  bw_mid;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       bw_ext;
  logic [CMP_W-1:0]       bw_mid_ext;

  always_comb begin
    sx       = b64u_pkg::sextet_of(character);
    use_char = char_present && (err == b64u_pkg::ST_OK) &&
               (character != b64u_pkg::CHAR_CR) && (character != b64u_pkg::CHAR_LF);

    cnt_c    = (lo_cnt > 3'd6) ? 3'd6 : lo_cnt;
    mask_in  = 6'((7'd1 << cnt_c) - 7'd1);
    acc      = {lo_bits & mask_in, sx.val};
    sum_cnt  = {1'b0, cnt_c} + 4'd6;
    full     = (sum_cnt >= 4'd8);
    rem      = full ? 3'(sum_cnt - 4'd8) : sum_cnt[2:0];
    dbyte    = 8'(acc >> rem);
    mask_out = 6'((7'd1 << rem) - 7'd1);

    cap_ext  = CMP_W'(capacity);
    bw_ext   = CMP_W'(bytes_wr);
    no_space = (bw_ext >= cap_ext) || (bytes_wr == '1);
    emit     = use_char && sx.ok && full && !no_space;

    err_mid  = err;
    bits_mid = lo_bits;
    cnt_mid  = lo_cnt;
    if (use_char) begin
      if (!sx.ok) begin
        err_mid = b64u_pkg::ST_INVALID;
      end else begin
        if (full && no_space) begin
          err_mid = b64u_pkg::ST_NOSPACE;
        end
        bits_mid = acc[5:0] & mask_out;
        cnt_mid  = rem;
      end
    end
    bw_mid     = emit ? bytes_wr + COUNT_BITS'(1) : bytes_wr;
    bw_mid_ext = CMP_W'(bw_mid);

    // six leftover bits can never finish a byte
    st_end = err_mid;
    if (err_mid == b64u_pkg::ST_OK && cnt_mid == 3'd6) begin
      st_end = b64u_pkg::ST_INVALID;
    end

    data_res.result_kind = b64u_pkg::RES_DATA;
    data_res.byte_value  = dbyte;
    data_res.status      = b64u_pkg::ST_OK;
    data_res.byte_count  = bw_mid_ext[15:0];
    data_res.last        = 1'b0;

    stat_res.result_kind = b64u_pkg::RES_STATUS;
    stat_res.byte_value  = 8'd0;
    stat_res.status      = st_end;
    stat_res.byte_count  = bw_mid_ext[15:0];
    stat_res.last        = 1'b1;

    res_a = emit ? data_res : stat_res;
    res_b = stat_res;
    n_res = {1'b0, emit} + {1'b0, end_of_message};

    if (end_of_message) begin
      lo_bits_nxt  = '0;
      lo_cnt_nxt   = '0;
      bytes_wr_nxt = '0;
      err_nxt      = b64u_pkg::ST_OK;
    end else begin
      lo_bits_nxt  = bits_mid;
      lo_cnt_nxt   = cnt_mid;
      bytes_wr_nxt = bw_mid;
      err_nxt      = err_mid;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b64u_res_fifo.sv
`default_nettype none

module b64u_res_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_n,
  input  b64u_pkg::res_t         push_a,
  input  b64u_pkg::res_t         push_b,
  output b64u_pkg::fifo_stat_t   stat,
  b64u_out_if.source             out_ch
);

  b64u_pkg::res_t                    mem_r [b64u_pkg::FIFO_DEPTH];
  logic [b64u_pkg::FIFO_AW-1:0]      wr_ptr_r;
  logic [b64u_pkg::FIFO_AW-1:0]      wr_ptr_nxt;
  logic [b64u_pkg::FIFO_AW-1:0]      wr_ptr_p1;
  logic [b64u_pkg::FIFO_AW-1:0]      rd_ptr_r;
  logic [b64u_pkg::FIFO_AW-1:0]      rd_ptr_nxt;
  logic [b64u_pkg::LVL_W-1:0]        lvl_r;
  logic [b64u_pkg::LVL_W-1:0]        lvl_nxt;
  logic                              pop;
  b64u_pkg::res_t                    head;

  assign head = mem_r[rd_ptr_r];
  assign pop  = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (lvl_r != '0);
  assign out_ch.result_kind = head.result_kind;
  assign out_ch.byte_value  = head.byte_value;
  assign out_ch.status      = head.status;
  assign out_ch.byte_count  = head.byte_count;
  assign out_ch.last        = head.last;

  // room for the worst case of two results per request
  assign stat.room  = (lvl_r <= b64u_pkg::LVL_W'(b64u_pkg::FIFO_DEPTH - 2));
  assign stat.level = lvl_r;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + b64u_pkg::FIFO_AW'(1);
    wr_ptr_nxt = wr_ptr_r + b64u_pkg::FIFO_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + b64u_pkg::FIFO_AW'(pop);
    lvl_nxt    = lvl_r + b64u_pkg::LVL_W'(push_n) - b64u_pkg::LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_b;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/base64url_unpadded_decoder_core.sv
// base64url decoder, unpadded alphabet, one character per request.
// in_ch carries character, char_present and end_of_message; out_ch returns
// data bytes (result_kind 0) and one status result per message (result_kind 1,
// last 1). cfg_ch writes output_capacity, the byte limit per message; it is
// always ready and should only be written while the block is idle.
// The results of a request are written into the result buffer at the edge
// that accepts it and reach out_ch once earlier results are taken. A request
// gives at most two results (a data byte and the status), which queue in the
// four-entry buffer; in_ch.ready is high while it has room for two results.
// Throughput: one request per cycle while out_ch takes a result per cycle;
// the shared output port limits it to one result per cycle overall.
// When the receiver stalls, results wait in the buffer and in_ch.ready drops
// once fewer than two entries are free; nothing is lost or reordered.
// Reset (rst_n low, synchronous) empties the buffer, clears the bit
// accumulator, byte count and latched status, and sets output_capacity to
// 65535. After each end-of-message the message state returns to that reset
// state; output_capacity is kept.
`default_nettype none

module base64url_unpadded_decoder_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  b64u_in_if.sink     in_ch,
  b64u_out_if.source  out_ch,
  b64u_cfg_if.sink    cfg_ch
);

  logic [15:0]            capacity_r;
  logic [5:0]             lo_bits_r;
  logic [5:0]             lo_bits_nxt;
  logic [2:0]             lo_cnt_r;
  logic [2:0]             lo_cnt_nxt;
  logic [COUNT_BITS-1:0]  bw_r;
  logic [COUNT_BITS-1:0]  bw_nxt;
  b64u_pkg::status_t      err_r;
  b64u_pkg::status_t      err_nxt;
  logic [1:0]             n_res;
  logic [1:0]             push_n;
  b64u_pkg::res_t         res_a;
  b64u_pkg::res_t         res_b;
  b64u_pkg::fifo_stat_t   fstat;
  logic                   in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = fstat.room;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign push_n       = in_acc ? n_res : 2'd0;

  b64u_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .character      (in_ch.character),
    .char_present   (in_ch.char_present),
    .end_of_message (in_ch.end_of_message),
    .capacity       (capacity_r),
    .lo_bits        (lo_bits_r),
    .lo_cnt         (lo_cnt_r),
    .bytes_wr       (bw_r),
    .err            (err_r),
    .lo_bits_nxt    (lo_bits_nxt),
    .lo_cnt_nxt     (lo_cnt_nxt),
    .bytes_wr_nxt   (bw_nxt),
    .err_nxt        (err_nxt),
    .n_res          (n_res),
    .res_a          (res_a),
    .res_b          (res_b)
  );

  b64u_res_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push_a (res_a),
    .push_b (res_b),
    .stat   (fstat),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'hFFFF;
      lo_bits_r  <= '0;
      lo_cnt_r   <= '0;
      bw_r       <= '0;
      err_r      <= b64u_pkg::ST_OK;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        capacity_r <= cfg_ch.data;
      end
      if (in_acc) begin
        lo_bits_r <= lo_bits_nxt;
        lo_cnt_r  <= lo_cnt_nxt;
        bw_r      <= bw_nxt;
        err_r     <= err_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= b64u_pkg::LVL_W'(b64u_pkg::FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_leftover_even: assert property (@(posedge clk) disable iff (!rst_n)
    lo_cnt_r == 3'd0 || lo_cnt_r == 3'd2 || lo_cnt_r == 3'd4 || lo_cnt_r == 3'd6)
    else $error("leftover bit count out of step");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.end_of_message) |=>
      (bw_r == '0 && lo_cnt_r == 3'd0 && err_r == b64u_pkg::ST_OK))
    else $error("message state not cleared after end of message");

  a_no_data_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != b64u_pkg::ST_OK) |->
      (res_a.result_kind == b64u_pkg::RES_STATUS && n_res != 2'd2))
    else $error("data byte produced after latched error");
`endif

endmodule

`default_nettype wire

FILE: test/tb_base64url_unpadded_decoder_core.sv
module tb_base64url_unpadded_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [15:0]    cfg_value;
    logic [7:0]     ch;
    logic           pres;
    logic           eom;
    logic           typed;
    b64u_pkg::res_t want;
  } dir_row_t;

  typedef struct packed {
    logic           typed;
    b64u_pkg::res_t want;
  } typed_entry_t;

  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_UC_B   = b64u_pkg::CHAR_UC_A + 8'd1;

  localparam b64u_pkg::res_t NO_RES      = b64u_pkg::res_t'(0);
  localparam b64u_pkg::res_t END_OK_0    =
    '{b64u_pkg::RES_STATUS, 8'h00, b64u_pkg::ST_OK, 16'd0, 1'b1};
  localparam b64u_pkg::res_t END_INV_0   =
    '{b64u_pkg::RES_STATUS, 8'h00, b64u_pkg::ST_INVALID, 16'd0, 1'b1};
  localparam b64u_pkg::res_t END_NOSPC_0 =
    '{b64u_pkg::RES_STATUS, 8'h00, b64u_pkg::ST_NOSPACE, 16'd0, 1'b1};

  localparam int NUM_ROWS = 27;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, 16'd0,    8'h00,                 1'b0, 1'b1, 1'b1, END_OK_0},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UNDER,  1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_LC_Z,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_LC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_CR,     1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_LF,     1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_0,      1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_9,      1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_DASH,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_Z,   1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b1, 1'b1, END_INV_0},
    '{ROW_ITEM, 16'd0,    CHAR_EQUALS,           1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    CHAR_UC_B,             1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    8'h00,                 1'b0, 1'b1, 1'b1, END_INV_0},
    '{ROW_ITEM, 16'd0,    8'hFF,                 1'b1, 1'b1, 1'b1, END_INV_0},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    CHAR_UC_B,             1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_CFG,  16'd0,    8'h00,                 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b1, 1'b1, END_NOSPC_0},
    '{ROW_CFG,  16'd1,    8'h00,                 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM, 16'd0,    b64u_pkg::CHAR_UC_A,   1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_CFG,  16'hFFFF, 8'h00,                 1'b0, 1'b0, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;
  int   errors = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  // decoder state as the block should hold it
  logic [15:0]       out_cap   = '1;
  logic [5:0]        held_bits = '0;
  int                held_cnt  = 0;
  logic [15:0]       msg_bytes = '0;
  b64u_pkg::status_t latched   = b64u_pkg::ST_OK;

  b64u_pkg::res_t decoded_q[$];
  typed_entry_t   typed_q[$];

  b64u_in_if  in_ch();
  b64u_out_if out_ch();
  b64u_cfg_if cfg_ch();

  base64url_unpadded_decoder_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int sextet_value(input logic [7:0] c);
    if (c >= b64u_pkg::CHAR_UC_A && c <= b64u_pkg::CHAR_UC_Z)
      return int'(c - b64u_pkg::CHAR_UC_A);
    if (c >= b64u_pkg::CHAR_LC_A && c <= b64u_pkg::CHAR_LC_Z)
      return int'(c - b64u_pkg::CHAR_LC_A) + 26;
    if (c >= b64u_pkg::CHAR_0 && c <= b64u_pkg::CHAR_9)
      return int'(c - b64u_pkg::CHAR_0) + 52;
    if (c == b64u_pkg::CHAR_DASH) return 62;
    if (c == b64u_pkg::CHAR_UNDER) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] random_b64_char();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return b64u_pkg::CHAR_UC_A + 8'(v);
    if (v < 52) return b64u_pkg::CHAR_LC_A + 8'(v - 26);
    if (v < 62) return b64u_pkg::CHAR_0 + 8'(v - 52);
    if (v == 62) return b64u_pkg::CHAR_DASH;
    return b64u_pkg::CHAR_UNDER;
  endfunction

  function automatic logic [7:0] random_illegal_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CHAR_EQUALS;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (sextet_value(c) >= 0 || c == b64u_pkg::CHAR_CR || c == b64u_pkg::CHAR_LF);
    return c;
  endfunction

  function automatic logic [15:0] pick_capacity();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return '1;
    if (r < 4) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 20));
  endfunction

  task automatic decode_item(input logic [7:0] c, input logic pres, input logic eom,
                             output int n, output b64u_pkg::res_t r0,
                             output b64u_pkg::res_t r1);
    int                v;
    int                bits;
    logic [11:0]       acc;
    b64u_pkg::res_t    r [2];
    b64u_pkg::status_t st;
    n    = 0;
    r[0] = NO_RES;
    r[1] = NO_RES;
    if (pres && latched == b64u_pkg::ST_OK && c != b64u_pkg::CHAR_CR &&
        c != b64u_pkg::CHAR_LF) begin
      v = sextet_value(c);
      if (v < 0) begin
        latched = b64u_pkg::ST_INVALID;
      end else begin
        acc  = {held_bits, v[5:0]};
        bits = held_cnt + 6;
        if (bits >= 8) begin
          bits -= 8;
          if (msg_bytes >= out_cap || msg_bytes == '1) begin
            latched = b64u_pkg::ST_NOSPACE;
          end else begin
            msg_bytes++;
            r[n] = '{b64u_pkg::RES_DATA, 8'(acc >> bits), b64u_pkg::ST_OK, msg_bytes, 1'b0};
            n++;
          end
        end
        held_cnt  = bits;
        held_bits = 6'(acc & ((12'd1 << bits) - 12'd1));
      end
    end
    if (eom) begin
      st = latched;
      if (st == b64u_pkg::ST_OK && held_cnt == 6) st = b64u_pkg::ST_INVALID;
      r[n] = '{b64u_pkg::RES_STATUS, 8'h00, st, msg_bytes, 1'b1};
      n++;
      held_bits = '0;
      held_cnt  = 0;
      msg_bytes = '0;
      latched   = b64u_pkg::ST_OK;
    end
    r0 = r[0];
    r1 = r[1];
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : monitor
    b64u_pkg::res_t got;
    b64u_pkg::res_t want;
    b64u_pkg::res_t r0;
    b64u_pkg::res_t r1;
    typed_entry_t   te;
    int             n;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_kind, out_ch.byte_value,
                b64u_pkg::status_t'(out_ch.status), out_ch.byte_count, out_ch.last};
        if (decoded_q.size() == 0) begin
          note_error($sformatf("unexpected result: kind %0d byte %02h status %0d count %0d",
                               got.result_kind, got.byte_value, got.status, got.byte_count));
        end else begin
          want = decoded_q.pop_front();
          if (got !== want)
            note_error($sformatf({"mismatch (exp/act): kind %0d/%0d byte %02h/%02h ",
                                  "status %0d/%0d count %0d/%0d last %0d/%0d"},
                                 want.result_kind, got.result_kind,
                                 want.byte_value, got.byte_value,
                                 want.status, got.status,
                                 want.byte_count, got.byte_count,
                                 want.last, got.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_item(in_ch.character, in_ch.char_present, in_ch.end_of_message, n, r0, r1);
        te = typed_q.pop_front();
        if (te.typed) begin
          decoded_q.push_back(te.want);
        end else begin
          if (n > 0) decoded_q.push_back(r0);
          if (n > 1) decoded_q.push_back(r1);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) out_cap = cfg_ch.data;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [7:0] c, input logic pres, input logic eom,
                           input logic typed, input b64u_pkg::res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.character      <= c;
    in_ch.char_present   <= pres;
    in_ch.end_of_message <= eom;
    typed_q.push_back('{typed, want});
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_char(input logic [7:0] c, input logic pres, input logic eom);
    send_item(c, pres, eom, 1'b0, NO_RES);
  endtask

  // let every outstanding result drain, plus the internal latency
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int         sent;
    int         kind;
    int         len;
    int         bad_pos;
    logic       eom_on_last;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 29) == 0) set_capacity(pick_capacity());
      kind        = $urandom_range(0, 99);
      len         = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(0, 24);
      bad_pos     = (kind >= 80 && kind < 92 && len > 0) ? $urandom_range(0, len - 1) : -1;
      eom_on_last = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_char(($urandom_range(0, 1) == 1) ? b64u_pkg::CHAR_CR : b64u_pkg::CHAR_LF,
                    1'b1, 1'b0);
          sent++;
        end
        // no character and no end: ignored, not counted
        if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        if (kind >= 92) c = 8'($urandom_range(0, 255));
        else if (i == bad_pos) c = random_illegal_char();
        else c = random_b64_char();
        send_char(c, (kind >= 92) ? 1'($urandom_range(0, 1)) : 1'b1,
                  eom_on_last && (i == len - 1));
        sent++;
      end
      if (!eom_on_last) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.character      = 8'h00;
    in_ch.char_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = 16'h0000;
    rst_n                = 1'b0;
    send_idle_pct        = 25;
    recv_idle_pct        = 64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        set_capacity(DIRECTED[i].cfg_value);
      end else begin
        send_item(DIRECTED[i].ch, DIRECTED[i].pres, DIRECTED[i].eom,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    set_capacity(pick_capacity());
    run_random(650);

    send_idle_pct = 64;
    recv_idle_pct = 25;
    set_capacity(pick_capacity());
    run_random(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(pick_capacity());
    run_random(650);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
